FILE: sv/msdm_pkg.sv
package msdm_pkg;

    localparam int UNITS_DEF           = 4;
    localparam int COIL_COUNT_DEF      = 256;
    localparam int DISCRETE_COUNT_DEF  = 256;
    localparam int HOLDING_COUNT_DEF   = 256;
    localparam int INPUT_REG_COUNT_DEF = 256;
    localparam int MAX_READ_REGS_DEF   = 31;
    localparam int REQ_DEPTH           = 68;

    localparam logic [15:0] COIL_ON_VALUE = 16'hFF00;
    localparam logic [7:0]  EXC_FLAG      = 8'h80;

    localparam logic [1:0] CMD_REQUEST   = 2'd0;
    localparam logic [1:0] CMD_DISCRETE  = 2'd1;
    localparam logic [1:0] CMD_INPUT_REG = 2'd2;
    localparam logic [1:0] CMD_UNUSED    = 2'd3;

    localparam logic [7:0] FC_READ_COILS    = 8'd1;
    localparam logic [7:0] FC_READ_DISCRETE = 8'd2;
    localparam logic [7:0] FC_READ_HOLDING  = 8'd3;
    localparam logic [7:0] FC_READ_INPUT    = 8'd4;
    localparam logic [7:0] FC_WRITE_COIL    = 8'd5;
    localparam logic [7:0] FC_WRITE_REG     = 8'd6;
    localparam logic [7:0] FC_WRITE_MULTI   = 8'd16;

    localparam logic [1:0] EXC_NONE     = 2'd0;
    localparam logic [1:0] EXC_FUNCTION = 2'd1;
    localparam logic [1:0] EXC_ADDRESS  = 2'd2;
    localparam logic [1:0] EXC_VALUE    = 2'd3;

    typedef struct packed {
        logic [1:0]  command;
        logic [1:0]  unit;
        logic [7:0]  request_byte;
        logic        request_last;
        logic [7:0]  local_address;
        logic [15:0] local_value;
    } req_t;

    typedef struct packed {
        logic [7:0] response_byte;
        logic       response_last;
        logic [1:0] exception_code;
    } rsp_t;

endpackage

FILE: sv/msdm_ram.sv
module msdm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: sv/modbus_server_data_model.sv
// After reset a clearing pass of max(UNITS * table size) entries (1024 by default) runs
// and no request is taken. Request bytes are then taken one per cycle while idle.
// After the last byte a decode state follows. A bit read packs eight bits per response
// byte, a register read sends high bytes first, FC16 writes each register.
// All table accesses share one read and one write port per table memory.
// The block accepts no request while it is answering one.
module modbus_server_data_model #(
    parameter int UNITS           = msdm_pkg::UNITS_DEF,
    parameter int COIL_COUNT      = msdm_pkg::COIL_COUNT_DEF,
    parameter int DISCRETE_COUNT  = msdm_pkg::DISCRETE_COUNT_DEF,
    parameter int HOLDING_COUNT   = msdm_pkg::HOLDING_COUNT_DEF,
    parameter int INPUT_REG_COUNT = msdm_pkg::INPUT_REG_COUNT_DEF,
    parameter int MAX_READ_REGS   = msdm_pkg::MAX_READ_REGS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  msdm_pkg::req_t req,
    input  logic           req_valid,
    output logic           req_stall,
    output msdm_pkg::rsp_t rsp,
    output logic           rsp_valid,
    input  logic           rsp_stall
);

    localparam int COIL_DEPTH  = UNITS * COIL_COUNT;
    localparam int DISC_DEPTH  = UNITS * DISCRETE_COUNT;
    localparam int HOLD_DEPTH  = UNITS * HOLDING_COUNT;
    localparam int INPUT_DEPTH = UNITS * INPUT_REG_COUNT;
    localparam int CA_W = $clog2(COIL_DEPTH);
    localparam int DA_W = $clog2(DISC_DEPTH);
    localparam int HA_W = $clog2(HOLD_DEPTH);
    localparam int IA_W = $clog2(INPUT_DEPTH);
    localparam int MAX_CD = (COIL_DEPTH > DISC_DEPTH) ? COIL_DEPTH : DISC_DEPTH;
    localparam int MAX_HI = (HOLD_DEPTH > INPUT_DEPTH) ? HOLD_DEPTH : INPUT_DEPTH;
    localparam int CLR_DEPTH = (MAX_CD > MAX_HI) ? MAX_CD : MAX_HI;
    localparam int CLR_W = $clog2(CLR_DEPTH);
    localparam int MAX_BITS = 16 * MAX_READ_REGS;
    localparam int OFF_W = $clog2(MAX_BITS + 9);
    localparam int I_W = $clog2(MAX_READ_REGS + 1);
    localparam int RB_W = $clog2(msdm_pkg::REQ_DEPTH);
    localparam int CNT_W = $clog2(msdm_pkg::REQ_DEPTH + 1);

    typedef enum logic [12:0] {
        S_CLEAR    = 13'b0000000000001,
        S_IDLE     = 13'b0000000000010,
        S_DECODE   = 13'b0000000000100,
        S_HEAD     = 13'b0000000001000,
        S_BIT_RD   = 13'b0000000010000,
        S_BIT_ACC  = 13'b0000000100000,
        S_BIT_EMIT = 13'b0000001000000,
        S_REG_RD   = 13'b0000010000000,
        S_REG_HI   = 13'b0000100000000,
        S_REG_LO   = 13'b0001000000000,
        S_WR_HI    = 13'b0010000000000,
        S_WR_LO    = 13'b0100000000000,
        S_WR_DO    = 13'b1000000000000
    } state_t;

    typedef enum logic [1:0] {
        K_EXC,
        K_ECHO,
        K_BITS,
        K_REGS
    } kind_t;

    state_t            state_reg, state_next;
    kind_t             kind_reg, kind_next, dec_kind;
    logic [1:0]        exc_reg, exc_next, dec_exc;
    logic [CLR_W-1:0]  clr_reg, clr_next;
    logic [CNT_W-1:0]  count_reg, count_next, len_reg, len_next, new_len;
    logic [7:0]        hdr_reg [6];
    logic [7:0]        hdr_next [6];
    logic [1:0]        unit_reg, unit_next;
    logic [2:0]        hidx_reg, hidx_next;
    logic [OFF_W-1:0]  off_reg, off_next;
    logic [I_W-1:0]    i_reg, i_next;
    logic [7:0]        acc_reg, acc_next;
    logic [7:0]        hi_reg, hi_next;
    msdm_pkg::rsp_t    rsp_reg, rsp_next;
    logic              rsp_valid_reg, rsp_valid_next;

    logic              accept, out_free, emit, unit_ok;
    msdm_pkg::rsp_t    emit_data;
    logic [7:0]        fc_w, bc_w, head_byte, lo_byte;
    logic [15:0]       a_w, q_w;
    logic [16:0]       sum_aq;
    logic [31:0]       bit_cnt, reg_cnt;

    logic              coil_we, disc_we, hold_we, input_we, rb_we;
    logic [CA_W-1:0]   coil_waddr, coil_addr;
    logic [DA_W-1:0]   disc_waddr, disc_raddr;
    logic [HA_W-1:0]   hold_waddr, hold_addr;
    logic [IA_W-1:0]   input_waddr, input_raddr;
    logic              coil_wdata, disc_wdata, coil_rdata, disc_rdata;
    logic [15:0]       hold_wdata, input_wdata, hold_rdata, input_rdata, reg_rdata;
    logic [RB_W-1:0]   rb_raddr;
    logic [7:0]        rb_rdata;

    assign req_stall = (state_reg != S_IDLE);
    assign accept    = req_valid && !req_stall;
    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign rsp       = rsp_reg;
    assign rsp_valid = rsp_valid_reg;

    assign fc_w   = hdr_reg[0];
    assign a_w    = {hdr_reg[1], hdr_reg[2]};
    assign q_w    = {hdr_reg[3], hdr_reg[4]};
    assign bc_w   = hdr_reg[5];
    assign sum_aq = 17'(a_w) + 17'(q_w);
    assign bit_cnt = (fc_w == msdm_pkg::FC_READ_COILS) ? 32'(COIL_COUNT) : 32'(DISCRETE_COUNT);
    assign reg_cnt = (fc_w == msdm_pkg::FC_READ_HOLDING) ? 32'(HOLDING_COUNT)
                                                         : 32'(INPUT_REG_COUNT);
    assign unit_ok = 32'(req.unit) < 32'(UNITS);
    assign new_len = (32'(count_reg) < 32'(msdm_pkg::REQ_DEPTH)) ? count_reg + 1'b1 : count_reg;

    assign coil_addr = CA_W'(32'(unit_reg) * 32'(COIL_COUNT) + 32'(a_w) + 32'(off_reg));
    assign disc_raddr = DA_W'(32'(unit_reg) * 32'(DISCRETE_COUNT) + 32'(a_w) + 32'(off_reg));
    assign hold_addr = HA_W'(32'(unit_reg) * 32'(HOLDING_COUNT) + 32'(a_w) + 32'(i_reg));
    assign input_raddr = IA_W'(32'(unit_reg) * 32'(INPUT_REG_COUNT) + 32'(a_w) + 32'(i_reg));
    assign reg_rdata = (fc_w == msdm_pkg::FC_READ_HOLDING) ? hold_rdata : input_rdata;
    assign rb_raddr = RB_W'(32'd6 + 32'({i_reg, 1'b0}) + 32'(state_reg == S_WR_LO));
    assign lo_byte = (32'd7 + 32'({i_reg, 1'b0}) < 32'(len_reg)) ? rb_rdata : 8'd0;

    always_comb
    begin
        dec_kind = K_EXC;
        dec_exc  = msdm_pkg::EXC_NONE;
        case (fc_w)
            msdm_pkg::FC_READ_COILS, msdm_pkg::FC_READ_DISCRETE:
            begin
                if (q_w == 16'd0 || 32'(q_w) > 32'(MAX_BITS))
                    dec_exc = msdm_pkg::EXC_VALUE;
                else if (32'(sum_aq) > bit_cnt)
                    dec_exc = msdm_pkg::EXC_ADDRESS;
                else
                    dec_kind = K_BITS;
            end
            msdm_pkg::FC_READ_HOLDING, msdm_pkg::FC_READ_INPUT:
            begin
                if (q_w == 16'd0 || 32'(q_w) > 32'(MAX_READ_REGS))
                    dec_exc = msdm_pkg::EXC_VALUE;
                else if (32'(sum_aq) > reg_cnt)
                    dec_exc = msdm_pkg::EXC_ADDRESS;
                else
                    dec_kind = K_REGS;
            end
            msdm_pkg::FC_WRITE_COIL:
            begin
                if (q_w != msdm_pkg::COIL_ON_VALUE && q_w != 16'd0)
                    dec_exc = msdm_pkg::EXC_VALUE;
                else if (32'(a_w) >= 32'(COIL_COUNT))
                    dec_exc = msdm_pkg::EXC_ADDRESS;
                else
                    dec_kind = K_ECHO;
            end
            msdm_pkg::FC_WRITE_REG:
            begin
                if (32'(a_w) >= 32'(HOLDING_COUNT))
                    dec_exc = msdm_pkg::EXC_ADDRESS;
                else
                    dec_kind = K_ECHO;
            end
            msdm_pkg::FC_WRITE_MULTI:
            begin
                if (q_w == 16'd0 || 32'(q_w) > 32'(MAX_READ_REGS)
                    || 17'(bc_w) != {q_w, 1'b0})
                    dec_exc = msdm_pkg::EXC_VALUE;
                else if (32'(sum_aq) > 32'(HOLDING_COUNT))
                    dec_exc = msdm_pkg::EXC_ADDRESS;
                else
                    dec_kind = K_ECHO;
            end
            default:
            begin
                dec_exc = msdm_pkg::EXC_FUNCTION;
            end
        endcase
    end

    always_comb
    begin
        case (hidx_reg)
            3'd0:
                head_byte = (kind_reg == K_EXC) ? (fc_w | msdm_pkg::EXC_FLAG) : fc_w;
            3'd1:
            begin
                case (kind_reg)
                    K_EXC:   head_byte = {6'd0, exc_reg};
                    K_ECHO:  head_byte = a_w[15:8];
                    K_BITS:  head_byte = 8'((17'(q_w) + 17'd7) >> 3);
                    default: head_byte = 8'({q_w, 1'b0});
                endcase
            end
            3'd2:    head_byte = a_w[7:0];
            3'd3:    head_byte = q_w[15:8];
            default: head_byte = q_w[7:0];
        endcase
    end

    always_comb
    begin
        coil_we    = 1'b0;
        coil_waddr = coil_addr;
        coil_wdata = (q_w == msdm_pkg::COIL_ON_VALUE);
        disc_we    = 1'b0;
        disc_waddr = DA_W'(32'(req.unit) * 32'(DISCRETE_COUNT) + 32'(req.local_address));
        disc_wdata = req.local_value[0];
        hold_we    = 1'b0;
        hold_waddr = hold_addr;
        hold_wdata = (state_reg == S_WR_DO) ? {hi_reg, lo_byte} : q_w;
        input_we    = 1'b0;
        input_waddr = IA_W'(32'(req.unit) * 32'(INPUT_REG_COUNT) + 32'(req.local_address));
        input_wdata = req.local_value;
        rb_we = accept && req.command == msdm_pkg::CMD_REQUEST
                && 32'(count_reg) < 32'(msdm_pkg::REQ_DEPTH);

        if (state_reg == S_CLEAR)
        begin
            coil_we     = 32'(clr_reg) < 32'(COIL_DEPTH);
            coil_waddr  = CA_W'(clr_reg);
            coil_wdata  = 1'b0;
            disc_we     = 32'(clr_reg) < 32'(DISC_DEPTH);
            disc_waddr  = DA_W'(clr_reg);
            disc_wdata  = 1'b0;
            hold_we     = 32'(clr_reg) < 32'(HOLD_DEPTH);
            hold_waddr  = HA_W'(clr_reg);
            hold_wdata  = 16'd0;
            input_we    = 32'(clr_reg) < 32'(INPUT_DEPTH);
            input_waddr = IA_W'(clr_reg);
            input_wdata = 16'd0;
        end
        else
        begin
            coil_we = state_reg == S_DECODE && fc_w == msdm_pkg::FC_WRITE_COIL
                      && dec_kind == K_ECHO;
            hold_we = (state_reg == S_DECODE && fc_w == msdm_pkg::FC_WRITE_REG
                       && dec_kind == K_ECHO) || state_reg == S_WR_DO;
            disc_we = accept && req.command == msdm_pkg::CMD_DISCRETE && unit_ok
                      && 32'(req.local_address) < 32'(DISCRETE_COUNT);
            input_we = accept && req.command == msdm_pkg::CMD_INPUT_REG && unit_ok
                       && 32'(req.local_address) < 32'(INPUT_REG_COUNT);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        kind_next  = kind_reg;
        exc_next   = exc_reg;
        clr_next   = clr_reg;
        count_next = count_reg;
        len_next   = len_reg;
        hdr_next   = hdr_reg;
        unit_next  = unit_reg;
        hidx_next  = hidx_reg;
        off_next   = off_reg;
        i_next     = i_reg;
        acc_next   = acc_reg;
        hi_next    = hi_reg;
        emit       = 1'b0;
        emit_data  = '{response_byte: 8'd0, response_last: 1'b0, exception_code: 2'd0};

        case (state_reg)
            S_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (32'(clr_reg) == CLR_DEPTH - 1)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                hidx_next = 3'd0;
                off_next  = '0;
                i_next    = '0;
                acc_next  = 8'd0;
                if (accept && req.command == msdm_pkg::CMD_REQUEST)
                begin
                    if (count_reg == '0)
                    begin
                        for (int j = 1; j < 6; j++)
                            hdr_next[j] = 8'd0;
                        hdr_next[0] = req.request_byte;
                    end
                    else if (32'(count_reg) < 32'd6)
                    begin
                        hdr_next[count_reg[2:0]] = req.request_byte;
                    end
                    count_next = new_len;
                    if (req.request_last)
                    begin
                        count_next = '0;
                        len_next   = new_len;
                        unit_next  = req.unit;
                        if (unit_ok)
                            state_next = S_DECODE;
                    end
                end
            end
            S_DECODE:
            begin
                kind_next = dec_kind;
                exc_next  = dec_exc;
                if (fc_w == msdm_pkg::FC_WRITE_MULTI && dec_kind == K_ECHO)
                    state_next = S_WR_HI;
                else
                    state_next = S_HEAD;
            end
            S_HEAD:
            begin
                if (out_free)
                begin
                    emit = 1'b1;
                    emit_data.response_byte = head_byte;
                    emit_data.exception_code = (kind_reg == K_EXC) ? exc_reg
                                                                   : msdm_pkg::EXC_NONE;
                    hidx_next = hidx_reg + 1'b1;
                    if (kind_reg == K_EXC && hidx_reg == 3'd1)
                    begin
                        emit_data.response_last = 1'b1;
                        state_next = S_IDLE;
                    end
                    else if (kind_reg == K_ECHO && hidx_reg == 3'd4)
                    begin
                        emit_data.response_last = 1'b1;
                        state_next = S_IDLE;
                    end
                    else if (kind_reg == K_BITS && hidx_reg == 3'd1)
                    begin
                        state_next = S_BIT_RD;
                    end
                    else if (kind_reg == K_REGS && hidx_reg == 3'd1)
                    begin
                        state_next = S_REG_RD;
                    end
                end
            end
            S_BIT_RD:
            begin
                state_next = S_BIT_ACC;
            end
            S_BIT_ACC:
            begin
                acc_next[off_reg[2:0]] = ((fc_w == msdm_pkg::FC_READ_COILS) ? coil_rdata
                                                                           : disc_rdata)
                                         && 32'(off_reg) < 32'(q_w);
                off_next = off_reg + 1'b1;
                state_next = (off_reg[2:0] == 3'd7) ? S_BIT_EMIT : S_BIT_RD;
            end
            S_BIT_EMIT:
            begin
                if (out_free)
                begin
                    emit = 1'b1;
                    emit_data.response_byte = acc_reg;
                    emit_data.response_last = 32'(off_reg) >= 32'(q_w);
                    acc_next = 8'd0;
                    state_next = (32'(off_reg) >= 32'(q_w)) ? S_IDLE : S_BIT_RD;
                end
            end
            S_REG_RD:
            begin
                state_next = S_REG_HI;
            end
            S_REG_HI:
            begin
                if (out_free)
                begin
                    emit = 1'b1;
                    emit_data.response_byte = reg_rdata[15:8];
                    state_next = S_REG_LO;
                end
            end
            S_REG_LO:
            begin
                if (out_free)
                begin
                    emit = 1'b1;
                    emit_data.response_byte = reg_rdata[7:0];
                    emit_data.response_last = 32'(i_reg) + 32'd1 == 32'(q_w);
                    i_next = i_reg + 1'b1;
                    state_next = (32'(i_reg) + 32'd1 == 32'(q_w)) ? S_IDLE : S_REG_RD;
                end
            end
            S_WR_HI:
            begin
                state_next = S_WR_LO;
            end
            S_WR_LO:
            begin
                hi_next = (32'd6 + 32'({i_reg, 1'b0}) < 32'(len_reg)) ? rb_rdata : 8'd0;
                state_next = S_WR_DO;
            end
            S_WR_DO:
            begin
                i_next = i_reg + 1'b1;
                state_next = (32'(i_reg) + 32'd1 == 32'(q_w)) ? S_HEAD : S_WR_HI;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (emit)
        begin
            rsp_next       = emit_data;
            rsp_valid_next = 1'b1;
        end
        else
        begin
            rsp_next       = rsp_reg;
            rsp_valid_next = rsp_valid_reg && rsp_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            kind_reg      <= K_EXC;
            exc_reg       <= msdm_pkg::EXC_NONE;
            clr_reg       <= '0;
            count_reg     <= '0;
            len_reg       <= '0;
            for (int j = 0; j < 6; j++)
                hdr_reg[j] <= 8'd0;
            unit_reg      <= 2'd0;
            hidx_reg      <= 3'd0;
            off_reg       <= '0;
            i_reg         <= '0;
            acc_reg       <= 8'd0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            kind_reg      <= kind_next;
            exc_reg       <= exc_next;
            clr_reg       <= clr_next;
            count_reg     <= count_next;
            len_reg       <= len_next;
            hdr_reg       <= hdr_next;
            unit_reg      <= unit_next;
            hidx_reg      <= hidx_next;
            off_reg       <= off_next;
            i_reg         <= i_next;
            acc_reg       <= acc_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hi_reg  <= hi_next;
        rsp_reg <= rsp_next;
    end

    msdm_ram #(.WIDTH(1), .DEPTH(COIL_DEPTH)) u_coil (
        .clk   (clk),
        .we    (coil_we),
        .waddr (coil_waddr),
        .wdata (coil_wdata),
        .raddr (coil_addr),
        .rdata (coil_rdata)
    );

    msdm_ram #(.WIDTH(1), .DEPTH(DISC_DEPTH)) u_disc (
        .clk   (clk),
        .we    (disc_we),
        .waddr (disc_waddr),
        .wdata (disc_wdata),
        .raddr (disc_raddr),
        .rdata (disc_rdata)
    );

    msdm_ram #(.WIDTH(16), .DEPTH(HOLD_DEPTH)) u_hold (
        .clk   (clk),
        .we    (hold_we),
        .waddr (hold_waddr),
        .wdata (hold_wdata),
        .raddr (hold_addr),
        .rdata (hold_rdata)
    );

    msdm_ram #(.WIDTH(16), .DEPTH(INPUT_DEPTH)) u_input (
        .clk   (clk),
        .we    (input_we),
        .waddr (input_waddr),
        .wdata (input_wdata),
        .raddr (input_raddr),
        .rdata (input_rdata)
    );

    msdm_ram #(.WIDTH(8), .DEPTH(msdm_pkg::REQ_DEPTH)) u_reqbuf (
        .clk   (clk),
        .we    (rb_we),
        .waddr (count_reg[RB_W-1:0]),
        .wdata (req.request_byte),
        .raddr (rb_raddr),
        .rdata (rb_rdata)
    );

endmodule

FILE: tb/sv/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NU = 4;
    localparam int TSZ = 256;
    localparam int MAXR = 31;

    class modbus_scoreboard;
        bit                 coils[NU*TSZ];
        bit                 discretes[NU*TSZ];
        logic [15:0]        holding[NU*TSZ];
        logic [15:0]        inregs[NU*TSZ];
        logic [7:0]         pdu[msdm_pkg::REQ_DEPTH];
        int                 pdu_len;
        msdm_pkg::rsp_t     pending[$];
        int                 mismatches;

        function new();
            foreach (coils[i])
            begin
                coils[i] = 0;
                discretes[i] = 0;
                holding[i] = '0;
                inregs[i] = '0;
            end
            pdu_len = 0;
            mismatches = 0;
        endfunction

        function logic [7:0] pdu_at(int idx);
            return (idx < pdu_len) ? pdu[idx] : 8'h00;
        endfunction

        function void emit(logic [7:0] b, logic [1:0] e);
            msdm_pkg::rsp_t r;
            r.response_byte = b;
            r.response_last = 1'b0;
            r.exception_code = e;
            pending.push_back(r);
        endfunction

        function void refuse(logic [7:0] fc, logic [1:0] e);
            emit(fc | msdm_pkg::EXC_FLAG, e);
            emit({6'd0, e}, e);
        endfunction

        function void echo(logic [7:0] fc, int a, int v);
            emit(fc, msdm_pkg::EXC_NONE);
            emit(a[15:8], msdm_pkg::EXC_NONE);
            emit(a[7:0], msdm_pkg::EXC_NONE);
            emit(v[15:8], msdm_pkg::EXC_NONE);
            emit(v[7:0], msdm_pkg::EXC_NONE);
        endfunction

        function void answer(int u);
            logic [7:0] fc;
            int a, q, b, base, bc, v;
            fc = pdu_at(0);
            a = int'({pdu_at(1), pdu_at(2)});
            q = int'({pdu_at(3), pdu_at(4)});
            base = u * TSZ;
            case (fc)
                msdm_pkg::FC_READ_COILS, msdm_pkg::FC_READ_DISCRETE:
                begin
                    if (q == 0 || q > 16 * MAXR) refuse(fc, msdm_pkg::EXC_VALUE);
                    else if (a + q > TSZ) refuse(fc, msdm_pkg::EXC_ADDRESS);
                    else
                    begin
                        emit(fc, msdm_pkg::EXC_NONE);
                        emit(8'((q + 7) / 8), msdm_pkg::EXC_NONE);
                        for (int i = 0; i < (q + 7) / 8; i++)
                        begin
                            b = 0;
                            for (int k = 0; k < 8; k++)
                                if (i * 8 + k < q &&
                                    ((fc == msdm_pkg::FC_READ_COILS)
                                     ? coils[base + a + i*8 + k]
                                     : discretes[base + a + i*8 + k]))
                                    b |= 1 << k;
                            emit(b[7:0], msdm_pkg::EXC_NONE);
                        end
                    end
                end
                msdm_pkg::FC_READ_HOLDING, msdm_pkg::FC_READ_INPUT:
                begin
                    if (q == 0 || q > MAXR) refuse(fc, msdm_pkg::EXC_VALUE);
                    else if (a + q > TSZ) refuse(fc, msdm_pkg::EXC_ADDRESS);
                    else
                    begin
                        emit(fc, msdm_pkg::EXC_NONE);
                        emit(8'(2 * q), msdm_pkg::EXC_NONE);
                        for (int i = 0; i < q; i++)
                        begin
                            v = int'((fc == msdm_pkg::FC_READ_HOLDING) ? holding[base + a + i]
                                                                      : inregs[base + a + i]);
                            emit(v[15:8], msdm_pkg::EXC_NONE);
                            emit(v[7:0], msdm_pkg::EXC_NONE);
                        end
                    end
                end
                msdm_pkg::FC_WRITE_COIL:
                begin
                    if (q != msdm_pkg::COIL_ON_VALUE && q != 0)
                        refuse(fc, msdm_pkg::EXC_VALUE);
                    else if (a >= TSZ) refuse(fc, msdm_pkg::EXC_ADDRESS);
                    else
                    begin
                        coils[base + a] = (q == msdm_pkg::COIL_ON_VALUE);
                        echo(fc, a, q);
                    end
                end
                msdm_pkg::FC_WRITE_REG:
                begin
                    if (a >= TSZ) refuse(fc, msdm_pkg::EXC_ADDRESS);
                    else
                    begin
                        holding[base + a] = q[15:0];
                        echo(fc, a, q);
                    end
                end
                msdm_pkg::FC_WRITE_MULTI:
                begin
                    bc = int'(pdu_at(5));
                    if (q == 0 || q > MAXR || bc != 2 * q) refuse(fc, msdm_pkg::EXC_VALUE);
                    else if (a + q > TSZ) refuse(fc, msdm_pkg::EXC_ADDRESS);
                    else
                    begin
                        for (int i = 0; i < q; i++)
                            holding[base + a + i] = {pdu_at(6 + 2*i), pdu_at(7 + 2*i)};
                        echo(fc, a, q);
                    end
                end
                default: refuse(fc, msdm_pkg::EXC_FUNCTION);
            endcase
            pending[$].response_last = 1'b1;
        endfunction

        function void note_request(msdm_pkg::req_t r);
            if (r.command == msdm_pkg::CMD_DISCRETE)
            begin
                discretes[r.unit * TSZ + r.local_address] = r.local_value[0];
                return;
            end
            if (r.command == msdm_pkg::CMD_INPUT_REG)
            begin
                inregs[r.unit * TSZ + r.local_address] = r.local_value;
                return;
            end
            if (r.command != msdm_pkg::CMD_REQUEST) return;
            if (pdu_len < msdm_pkg::REQ_DEPTH)
            begin
                pdu[pdu_len] = r.request_byte;
                pdu_len++;
            end
            if (!r.request_last) return;
            answer(r.unit);
            pdu_len = 0;
        endfunction

        function void check_response(msdm_pkg::rsp_t got);
            msdm_pkg::rsp_t exp;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected response byte %h last %b exc %0d",
                             got.response_byte, got.response_last, got.exception_code);
                return;
            end
            exp = pending.pop_front();
            if (got !== exp)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Mismatch: expected byte %h last %b exc %0d, got %h %b %0d",
                             exp.response_byte, exp.response_last, exp.exception_code,
                             got.response_byte, got.response_last, got.exception_code);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    msdm_pkg::req_t req;
    logic req_valid;
    logic req_stall;
    msdm_pkg::rsp_t rsp;
    logic rsp_valid;
    logic rsp_stall;
    modbus_scoreboard board;
    bit idle_free;

    modbus_server_data_model DUT (
        .clk(clk), .rst_n(rst_n), .req(req), .req_valid(req_valid),
        .req_stall(req_stall), .rsp(rsp), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            board.check_response(rsp);
    end

    initial
    begin
        int w;
        rsp_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            w = idle_free ? 0 : $urandom_range(0, 14);
            if (w > 0 && $urandom_range(0, 3) != 0)
            begin
                rsp_stall <= 1'b1;
                repeat (w) @(negedge clk);
                rsp_stall <= 1'b0;
            end
        end
    end

    task automatic send_request(msdm_pkg::req_t r);
        int w;
        w = idle_free ? 0 : $urandom_range(0, 14);
        if ($urandom_range(0, 3) == 0) w = 0;
        if (w > 0)
        begin
            req_valid <= 1'b0;
            repeat (w) @(negedge clk);
        end
        req <= r;
        req_valid <= 1'b1;
        do @(posedge clk); while (req_stall);
        board.note_request(r);
        @(negedge clk);
    endtask

    task automatic send_byte(int u, int b, bit last);
        msdm_pkg::req_t r;
        r = '0;
        r.command = msdm_pkg::CMD_REQUEST;
        r.unit = 2'(u);
        r.request_byte = 8'(b);
        r.request_last = last;
        r.local_address = 8'($urandom);
        r.local_value = 16'($urandom);
        send_request(r);
    endtask

    task automatic send_pdu(int u, logic [7:0] bytes[$]);
        foreach (bytes[i])
            send_byte(u, bytes[i], i == bytes.size() - 1);
    endtask

    task automatic local_write(logic [1:0] cmd, int u, int a, int v);
        msdm_pkg::req_t r;
        r = '0;
        r.command = cmd;
        r.unit = 2'(u);
        r.local_address = 8'(a);
        r.local_value = 16'(v);
        r.request_byte = 8'($urandom);
        r.request_last = 1'($urandom);
        send_request(r);
    endtask

    task automatic simple_pdu(int u, logic [7:0] fc, int a, int q);
        send_pdu(u, '{fc, a[15:8], a[7:0], q[15:8], q[7:0]});
    endtask

    task automatic multi_write(int u, int a, int q, int bc);
        logic [7:0] p[$];
        p = '{msdm_pkg::FC_WRITE_MULTI, a[15:8], a[7:0], q[15:8], q[7:0], bc[7:0]};
        for (int i = 0; i < 2 * q; i++) p.push_back(8'($urandom));
        send_pdu(u, p);
    endtask

    task automatic random_pdu();
        int u, k, a, q, n;
        logic [7:0] p[$];
        u = $urandom_range(0, 3);
        k = $urandom_range(0, 19);
        a = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 255);
        case (k)
            0, 1, 2:
            begin
                q = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 600) : $urandom_range(1, 40);
                if (a + q > 256 && $urandom_range(0, 2) != 0) a = 256 - q;
                if (a < 0) a = 0;
                simple_pdu(u, $urandom_range(0, 1) ? msdm_pkg::FC_READ_COILS
                                                   : msdm_pkg::FC_READ_DISCRETE, a, q);
            end
            3, 4, 5:
            begin
                q = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 40) : $urandom_range(1, 8);
                if (a + q > 256 && $urandom_range(0, 2) != 0) a = 256 - q;
                if (a < 0) a = 0;
                simple_pdu(u, $urandom_range(0, 1) ? msdm_pkg::FC_READ_HOLDING
                                                   : msdm_pkg::FC_READ_INPUT, a, q);
            end
            6, 7:
                simple_pdu(u, msdm_pkg::FC_WRITE_COIL, a, ($urandom_range(0, 4) == 0) ? $urandom :
                           ($urandom_range(0, 1) ? 32'hFF00 : 0));
            8, 9:
                simple_pdu(u, msdm_pkg::FC_WRITE_REG, a, $urandom);
            10, 11, 12:
            begin
                q = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 33) : $urandom_range(1, 6);
                if (a + q > 256 && $urandom_range(0, 2) != 0) a = 256 - q;
                if (a < 0) a = 0;
                multi_write(u, a, q, ($urandom_range(0, 6) == 0) ? $urandom_range(0, 255) : 2 * q);
            end
            13, 14:
                local_write(msdm_pkg::CMD_DISCRETE, u, $urandom, $urandom);
            15, 16:
                local_write(msdm_pkg::CMD_INPUT_REG, u, $urandom, $urandom);
            default:
            begin
                n = $urandom_range(1, 8);
                for (int i = 0; i < n; i++) p.push_back(8'($urandom));
                send_pdu(u, p);
            end
        endcase
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        while (board.pending.size() != 0) @(negedge clk);
        @(negedge clk);
    endtask

    initial
    begin
        logic [7:0] longp[$];
        board = new();
        idle_free = 0;
        rst_n = 1'b0;
        req = '0;
        req_valid = 1'b0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        local_write(msdm_pkg::CMD_DISCRETE, 3, 255, 16'hFFFF);
        local_write(msdm_pkg::CMD_DISCRETE, 0, 0, 16'h0001);
        local_write(msdm_pkg::CMD_INPUT_REG, 3, 255, 16'hA55A);
        local_write(msdm_pkg::CMD_INPUT_REG, 0, 0, 16'hFFFF);
        local_write(msdm_pkg::CMD_UNUSED, 1, 5, 16'h1234);
        simple_pdu(0, msdm_pkg::FC_WRITE_COIL, 0, 16'hFF00);
        simple_pdu(3, msdm_pkg::FC_WRITE_COIL, 255, 16'hFF00);
        simple_pdu(0, msdm_pkg::FC_WRITE_COIL, 1, 16'h1234);
        simple_pdu(0, msdm_pkg::FC_WRITE_COIL, 256, 0);
        simple_pdu(2, msdm_pkg::FC_WRITE_REG, 255, 16'hFFFF);
        simple_pdu(2, msdm_pkg::FC_WRITE_REG, 256, 1);
        simple_pdu(0, msdm_pkg::FC_READ_COILS, 0, 496);
        simple_pdu(3, msdm_pkg::FC_READ_DISCRETE, 250, 6);
        simple_pdu(0, msdm_pkg::FC_READ_DISCRETE, 0, 497);
        simple_pdu(0, msdm_pkg::FC_READ_COILS, 0, 0);
        simple_pdu(1, msdm_pkg::FC_READ_COILS, 250, 7);
        simple_pdu(3, msdm_pkg::FC_READ_INPUT, 225, 31);
        simple_pdu(2, msdm_pkg::FC_READ_HOLDING, 255, 1);
        simple_pdu(0, msdm_pkg::FC_READ_HOLDING, 0, 32);
        multi_write(1, 0, 31, 62);
        multi_write(1, 250, 7, 14);
        multi_write(1, 0, 2, 3);
        send_pdu(0, '{msdm_pkg::FC_WRITE_MULTI, 8'd0, 8'd0});
        send_pdu(2, '{8'hFF});
        send_pdu(0, '{msdm_pkg::FC_READ_HOLDING});
        for (int i = 0; i < 72; i++) longp.push_back(8'($urandom));
        longp[0] = msdm_pkg::FC_WRITE_MULTI;
        send_pdu(0, longp);
        drain();

        for (int i = 0; i < 10; i++) random_pdu();
        drain();
        idle_free = 1;
        for (int i = 0; i < 5; i++) random_pdu();
        idle_free = 0;
        for (int i = 0; i < 8; i++) random_pdu();
        drain();
        repeat (400) @(negedge clk);

        if (board.mismatches == 0 && board.pending.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("Regression FAIL");
        $finish;
    end
endmodule

FILE: filelist.f
sv/msdm_pkg.sv
sv/msdm_ram.sv
sv/modbus_server_data_model.sv
tb/sv/tb_top.sv
